FILE: rtl/core/shash_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package shash_pkg;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int ROUNDS          = 64;
    localparam int DIGEST_WORDS    = 8;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;
    // first word index whose padding no longer leaves room for the length
    localparam logic [3:0]  LEN_WORD  = 4'd14;

    localparam logic [31:0] IV [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        OP_ABSORB  = 2'd0,
        OP_FINISH  = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        K_WORD    = 2'd0,
        K_FINISH  = 2'd1,
        K_RESTART = 2'd2
    } t_kind;

    // word: four message bytes, or for finish the padded partial word
    typedef struct packed {
        t_kind       kind;
        logic [31:0] word;
        logic [1:0]  nbytes;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_ROUND  = 2'd1,
        S_UPDATE = 2'd2,
        S_EMIT   = 2'd3
    } t_state;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        unique case (r)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

FILE: rtl/core/shash_if.sv
// Valid/ready channel interfaces for the hasher's input and digest output.
interface shash_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface shash_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                    output ready);
endinterface

FILE: rtl/core/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: front end, entry queue, compressor.
//
//  channel  | dir | payload                              | accepted when
//  ---------+-----+--------------------------------------+-----------------
//  i_in     | in  | opcode[1:0], data_byte[7:0]          | valid && ready
//  o_out    | out | digest_word[31:0], word_index, last  | valid && ready
//
// The front takes one item per cycle while the queue has room; four bytes make one entry.
// While the compressor runs the rounds and the chaining update of a full block, only the queue
// (QUEUE_DEPTH entries) and the front's partial word take bytes.
// Finish: one block is compressed, or two when 56 or more bytes are pending, then eight output
// items, one per cycle while o_out.ready is high; a stalled output holds its word.
// Reset is synchronous: counts clear and the chaining words load the initial hash values.
module sha256_stream_hasher
    import shash_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shash_in_if.sink    i_in,
    shash_out_if.source o_out
);

    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    shash_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    shash_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    shash_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/core/shash_front.sv
// Front end: accepts items, packs bytes into words, pads the partial word on finish.
module shash_front
    import shash_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    shash_in_if.sink    i_in,
    output logic        o_push_valid,
    output t_entry      o_push_entry,
    input  logic        i_push_ready
);

    logic [1:0]  r_nb;
    logic [23:0] r_word;
    logic        accept;
    t_op         op;
    logic [31:0] padded;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;
    assign op         = t_op'(i_in.opcode);

    always_comb begin
        unique case (r_nb)
            2'd0: padded = {PAD_BYTE, 24'h0};
            2'd1: padded = {r_word[7:0], PAD_BYTE, 16'h0};
            2'd2: padded = {r_word[15:0], PAD_BYTE, 8'h0};
            2'd3: padded = {r_word[23:0], PAD_BYTE};
        endcase
    end

    always_comb begin
        o_push_valid        = 1'b0;
        o_push_entry.kind   = K_WORD;
        o_push_entry.word   = {r_word, i_in.data_byte};
        o_push_entry.nbytes = r_nb;
        unique case (op)
            OP_ABSORB: begin
                o_push_valid = accept && (r_nb == 2'd3);
            end
            OP_FINISH: begin
                o_push_valid      = accept;
                o_push_entry.kind = K_FINISH;
                o_push_entry.word = padded;
            end
            OP_RESTART: begin
                o_push_valid      = accept;
                o_push_entry.kind = K_RESTART;
            end
            default: o_push_valid = 1'b0;  // unused opcode is dropped
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb <= 2'd0;
        end else if (accept) begin
            if (op == OP_ABSORB) begin
                r_nb <= r_nb + 2'd1;
            end else if (op == OP_FINISH || op == OP_RESTART) begin
                r_nb <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && op == OP_ABSORB) begin
            r_word <= {r_word[15:0], i_in.data_byte};
        end
    end

endmodule

FILE: rtl/core/shash_queue.sv
// Small FIFO of classified entries between the front end and the compressor.
module shash_queue
    import shash_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_entry i_push_entry,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_entry,
    input  logic   i_pop_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

endmodule

FILE: rtl/core/shash_back.sv
// Back end: block assembly, final padding, 64-round compressor and digest output.
module shash_back
    import shash_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    input  t_entry     i_pop_entry,
    output logic       o_pop_ready,
    shash_out_if.source o_out
);

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_w     [WORDS_PER_BLOCK];
    logic [31:0] r_v     [DIGEST_WORDS];
    logic [31:0] r_chain [DIGEST_WORDS];
    logic [31:0] sum     [DIGEST_WORDS];
    logic [3:0]  r_wc;
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_fin;
    logic        r_second;

    logic        pop;
    logic        take_word;
    logic        block_full;
    logic        start_fin;
    logic        emit_done;
    logic        do_restart;
    logic [63:0] len;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    assign pop        = i_pop_valid && o_pop_ready;
    assign take_word  = pop && (i_pop_entry.kind == K_WORD);
    assign block_full = take_word && (r_wc == 4'(WORDS_PER_BLOCK - 1));
    assign start_fin  = pop && (i_pop_entry.kind == K_FINISH);
    assign emit_done  = (r_state == S_EMIT) && o_out.ready && (r_idx == 3'(DIGEST_WORDS - 1));
    assign do_restart = (pop && (i_pop_entry.kind == K_RESTART)) || emit_done;
    // pending bytes times eight is {word count, byte count, 000}
    assign len        = r_bits + 64'({r_wc, i_pop_entry.nbytes, 3'b000});

    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + round_k(r_round) + r_w[0];
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];

    always_comb begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
            sum[i] = r_chain[i] + r_v[i];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (block_full || start_fin) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_round == 6'(ROUNDS - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_second) begin
                    n_state = S_ROUND;
                end else if (r_fin) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (emit_done) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_pop_ready = (r_state == S_IDLE);
        o_out.valid = (r_state == S_EMIT);
    end

    assign o_out.digest_word = r_chain[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last        = (r_idx == 3'(DIGEST_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wc     <= 4'd0;
            r_bits   <= 64'd0;
            r_chain  <= IV;
            r_round  <= 6'd0;
            r_idx    <= 3'd0;
            r_fin    <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= (r_state == S_ROUND) ? r_round + 6'd1 : 6'd0;
            if (take_word) begin
                r_wc <= r_wc + 4'd1;
            end
            if (start_fin) begin
                r_wc     <= 4'd0;
                r_bits   <= len;
                r_fin    <= 1'b1;
                r_second <= (r_wc >= LEN_WORD);
            end
            if (r_state == S_UPDATE) begin
                r_chain  <= sum;
                r_second <= 1'b0;
                if (!r_fin) begin
                    r_bits <= r_bits + BLOCK_BITS;
                end
            end
            if (r_state == S_EMIT && o_out.ready) begin
                r_idx <= r_idx + 3'd1;
            end
            if (do_restart) begin
                r_wc    <= 4'd0;
                r_bits  <= 64'd0;
                r_chain <= IV;
                r_fin   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_word) begin
            r_w[r_wc] <= i_pop_entry.word;
        end
        if (block_full) begin
            r_v <= r_chain;
        end
        if (start_fin) begin
            for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
                if (4'(i) > r_wc) begin
                    r_w[i] <= 32'h0;
                end
            end
            r_w[r_wc] <= i_pop_entry.word;
            if (r_wc < LEN_WORD) begin
                r_w[WORDS_PER_BLOCK-2] <= len[63:32];
                r_w[WORDS_PER_BLOCK-1] <= len[31:0];
            end
            r_v <= r_chain;
        end
        if (r_state == S_ROUND) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[WORDS_PER_BLOCK-1] <= w_new;
        end
        // extra length-only block after a full padded one
        if (r_state == S_UPDATE && r_second) begin
            r_v <= sum;
            for (int i = 0; i < WORDS_PER_BLOCK - 2; i++) begin
                r_w[i] <= 32'h0;
            end
            r_w[WORDS_PER_BLOCK-2] <= r_bits[63:32];
            r_w[WORDS_PER_BLOCK-1] <= r_bits[31:0];
        end
    end

endmodule

FILE: rtl/core/shash_checker.sv
// Port-level checks on the digest output of the hasher, bound to the top level.
module shash_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_word,
    input logic [2:0]  i_index,
    input logic        i_last
);

    // digest words come out back to back, in order
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_valid && (i_index == $past(i_index) + 3'd1))
        else $error("digest word index did not advance");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_index == 3'd7)))
        else $error("last flag does not match the final word index");

    // a new digest needs a fresh compression, so output drops after the last word
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_last |=> !i_valid)
        else $error("output still valid right after the last digest word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_word) && $stable(i_index))
        else $error("stalled digest item changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid right after reset");

endmodule

bind sha256_stream_hasher shash_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_word  (o_out.digest_word),
    .i_index (o_out.word_index),
    .i_last  (o_out.last)
);
